// ===== src/kmep_pkg.sv =====
package kmep_pkg;

    localparam int KEY_ROWS = 8;
    localparam int KEY_COLS = 5;

    localparam int ACT_W   = 3;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int PORT_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;
    localparam int PEND_W  = 4;
    localparam int COLOR_W = 3;

    // Actions carried by an input beat.
    localparam logic [ACT_W-1:0] ACT_ENQUEUE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FRAME_TICK = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PORT_READ  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PORT_WRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_KEY_SET    = 3'd4;

    // Configuration register indexes, taken from paddr bit 2.
    localparam logic REG_HOLD = 1'b0;
    localparam logic REG_GAP  = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0]   HOLD_RESET   = 3'd5;
    localparam logic [CNT_W-1:0]   GAP_RESET    = 3'd3;
    localparam logic [COLOR_W-1:0] BORDER_RESET = 3'd7;

    localparam logic [BYTE_W-1:0]   READ_IDLE  = 8'hFF;
    localparam logic [BYTE_W-1:0]   READ_MARK  = 8'hA0;
    localparam logic [KEY_COLS-1:0] ROW_ALL_UP = 5'h1F;
    localparam logic [PEND_W-1:0]   PEND_MAX   = 4'd15;
    localparam int                  BEEPER_BIT = 4;

    typedef struct packed {
        logic             pressed;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } key_event_t;

    typedef logic [KEY_ROWS-1:0][KEY_COLS-1:0] key_matrix_t;

    // Work handed from the top level to the key matrix for one beat.
    typedef struct packed {
        logic       tick;
        logic       key_set;
        key_event_t ev;
    } key_op_t;

    // Queue status seen by the top level and the key matrix.
    typedef struct packed {
        logic              empty;
        logic              full;
        key_event_t        head;
        logic [PEND_W-1:0] pending_next;
    } queue_stat_t;

endpackage

// ===== src/kmep_if.sv =====
interface kmep_in_if;
    logic                           valid;
    logic                           ready;
    logic [kmep_pkg::ACT_W-1:0]     action;
    logic [kmep_pkg::ROW_W-1:0]     key_row;
    logic [kmep_pkg::COL_W-1:0]     key_col;
    logic                           key_pressed;
    logic [kmep_pkg::PORT_W-1:0]    port_address;
    logic [kmep_pkg::BYTE_W-1:0]    write_value;

    modport source (output valid, action, key_row, key_col, key_pressed, port_address,
                    write_value, input ready);
    modport sink (input valid, action, key_row, key_col, key_pressed, port_address,
                  write_value, output ready);
endinterface

interface kmep_out_if;
    logic                           valid;
    logic                           ready;
    logic [kmep_pkg::BYTE_W-1:0]    read_data;
    logic [kmep_pkg::COLOR_W-1:0]   border_color;
    logic                           beeper_level;
    logic [kmep_pkg::PEND_W-1:0]    queue_pending;
    logic                           event_dropped;

    modport source (output valid, read_data, border_color, beeper_level, queue_pending,
                    event_dropped, input ready);
    modport sink (input valid, read_data, border_color, beeper_level, queue_pending,
                  event_dropped, output ready);
endinterface

// ===== src/kmep_cfg.sv =====
module kmep_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kmep_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kmep_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kmep_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [kmep_pkg::CNT_W-1:0]         hold_frames,
    output logic [kmep_pkg::CNT_W-1:0]         quiet_frames
);

    logic [kmep_pkg::CNT_W-1:0] hold_reg;
    logic [kmep_pkg::CNT_W-1:0] gap_reg;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= kmep_pkg::HOLD_RESET;
            gap_reg  <= kmep_pkg::GAP_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == kmep_pkg::REG_HOLD)
                hold_reg <= pwdata[kmep_pkg::CNT_W-1:0];
            else
                gap_reg <= pwdata[kmep_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            kmep_pkg::REG_HOLD: prdata = kmep_pkg::APB_DATA_W'(hold_reg);
            kmep_pkg::REG_GAP:  prdata = kmep_pkg::APB_DATA_W'(gap_reg);
            default:            prdata = '0;
        endcase
    end

    assign hold_frames  = hold_reg;
    assign quiet_frames = gap_reg;

endmodule

// ===== src/kmep_queue.sv =====
module kmep_queue
#(
    parameter int DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  kmep_pkg::key_event_t   push_data,
    input  logic                   pop,
    output kmep_pkg::queue_stat_t  stat
);

    localparam int PW = $clog2(DEPTH);

    kmep_pkg::key_event_t mem [DEPTH];
    kmep_pkg::key_event_t head_data_reg;

    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [PW-1:0] tail_reg;
    logic [PW-1:0] tail_next;
    logic [PW-1:0] tail_inc;
    logic [PW-1:0] head_inc;
    logic [PW+4:0] pend_wide;

    assign tail_inc = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign head_next = pop ? head_inc : head_reg;
    assign tail_next = push ? tail_inc : tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // The read port is registered from the next head pointer, so it tracks the head,
    // with a bypass for an event written into the slot that becomes the head.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= push_data;
        if (push && (tail_reg == head_next))
            head_data_reg <= push_data;
        else
            head_data_reg <= mem[head_next];
    end

    always_comb
    begin
        if (tail_next >= head_next)
            pend_wide = (PW+5)'(tail_next) - (PW+5)'(head_next);
        else
            pend_wide = (PW+5)'(tail_next) + (PW+5)'(DEPTH) - (PW+5)'(head_next);
    end

    assign stat.empty        = (head_reg == tail_reg);
    assign stat.full         = (tail_inc == head_reg);
    assign stat.head         = head_data_reg;
    assign stat.pending_next = (pend_wide > (PW+5)'(kmep_pkg::PEND_MAX)) ?
                               kmep_pkg::PEND_MAX : pend_wide[kmep_pkg::PEND_W-1:0];

endmodule

// ===== src/kmep_keys.sv =====
module kmep_keys
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  kmep_pkg::key_op_t            op,
    input  logic [kmep_pkg::CNT_W-1:0]   hold_frames,
    input  logic [kmep_pkg::CNT_W-1:0]   quiet_frames,
    input  kmep_pkg::queue_stat_t        qstat,
    output logic                         pop,
    output kmep_pkg::key_matrix_t        matrix
);

    kmep_pkg::key_matrix_t mat_reg;
    kmep_pkg::key_matrix_t mat_next;

    logic [kmep_pkg::CNT_W-1:0] cnt_reg  [kmep_pkg::KEY_ROWS][kmep_pkg::KEY_COLS];
    logic [kmep_pkg::CNT_W-1:0] cnt_next [kmep_pkg::KEY_ROWS][kmep_pkg::KEY_COLS];
    logic [kmep_pkg::CNT_W-1:0] gap_reg;
    logic [kmep_pkg::CNT_W-1:0] gap_next;

    logic                 holding;
    logic                 holding_after;
    logic                 apply;
    logic                 hit;
    kmep_pkg::key_event_t ev;

    always_comb
    begin
        holding       = 1'b0;
        holding_after = 1'b0;
        for (int r = 0; r < kmep_pkg::KEY_ROWS; r++)
        begin
            for (int c = 0; c < kmep_pkg::KEY_COLS; c++)
            begin
                holding       = holding | (cnt_reg[r][c] != '0);
                holding_after = holding_after | (cnt_reg[r][c] > kmep_pkg::CNT_W'(1));
            end
        end
    end

    always_comb
    begin
        mat_next = mat_reg;
        cnt_next = cnt_reg;
        gap_next = gap_reg;
        pop      = 1'b0;
        apply    = 1'b0;
        hit      = 1'b0;
        ev       = op.ev;

        if (op.tick)
        begin
            if (holding)
            begin
                for (int r = 0; r < kmep_pkg::KEY_ROWS; r++)
                begin
                    for (int c = 0; c < kmep_pkg::KEY_COLS; c++)
                    begin
                        if (cnt_reg[r][c] != '0)
                            cnt_next[r][c] = cnt_reg[r][c] - 1'b1;
                        if (cnt_reg[r][c] == kmep_pkg::CNT_W'(1))
                            mat_next[r][c] = 1'b1;
                    end
                end
                if (!holding_after)
                    gap_next = quiet_frames;
            end
            else if (gap_reg != '0)
            begin
                gap_next = gap_reg - 1'b1;
            end
            else if (!qstat.empty)
            begin
                pop   = 1'b1;
                apply = 1'b1;
                ev    = qstat.head;
            end
        end
        else if (op.key_set)
        begin
            apply = 1'b1;
        end

        // Counters are untouched on both apply paths, so the current values
        // stand in for the ones the event sees.
        if (apply && (ev.col < kmep_pkg::COL_W'(kmep_pkg::KEY_COLS)))
        begin
            for (int r = 0; r < kmep_pkg::KEY_ROWS; r++)
            begin
                for (int c = 0; c < kmep_pkg::KEY_COLS; c++)
                begin
                    hit = (ev.row == kmep_pkg::ROW_W'(r)) && (ev.col == kmep_pkg::COL_W'(c));
                    if (ev.pressed)
                    begin
                        if (hit)
                        begin
                            mat_next[r][c] = 1'b0;
                            cnt_next[r][c] = '0;
                        end
                        else if (cnt_reg[r][c] != '0)
                        begin
                            mat_next[r][c] = 1'b1;
                            cnt_next[r][c] = '0;
                        end
                    end
                    else if (hit)
                    begin
                        cnt_next[r][c] = hold_frames;
                        if (hold_frames == '0)
                            mat_next[r][c] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= '1;
            gap_reg <= '0;
            for (int r = 0; r < kmep_pkg::KEY_ROWS; r++)
                for (int c = 0; c < kmep_pkg::KEY_COLS; c++)
                    cnt_reg[r][c] <= '0;
        end
        else
        begin
            mat_reg <= mat_next;
            gap_reg <= gap_next;
            cnt_reg <= cnt_next;
        end
    end

    assign matrix = mat_reg;

endmodule

// ===== src/keyboard_matrix_event_pacer.sv =====
// Keyboard matrix and I/O port block. Each input beat carries one action: queue a
// key event, advance one video frame, read or write the I/O port, or set a key
// directly. Each accepted beat yields exactly one result beat, in order. The block
// takes one beat per clock while the result side is not stalled: a beat is caught
// in an input register, all of its work (counter updates, queue access, port
// decode) is done by the logic behind that register, and the result lands in an
// output register. The output register is refilled in the cycle it is taken,
// and input ready drops only while both stages are full and the result side is
// stalled. Key events wait in a ring queue of QUEUE_DEPTH slots that keeps one
// slot free, so it holds QUEUE_DEPTH-1 events; an event offered to a full queue
// is dropped and flagged in its result. The queue needs no clearing after reset.
// Configuration (release hold and gap frames) is to be written over the APB port
// only while no beat is in flight; the block itself does not enforce this.
module keyboard_matrix_event_pacer
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    kmep_in_if.sink                            items,
    kmep_out_if.source                         results,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kmep_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kmep_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kmep_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // Input stage.
    logic                              in_vld_reg;
    logic [kmep_pkg::ACT_W-1:0]        act_reg;
    kmep_pkg::key_event_t              ev_reg;
    logic [kmep_pkg::PORT_W-1:0]       port_reg;
    logic [kmep_pkg::BYTE_W-1:0]       wval_reg;

    // Output stage.
    logic                              out_vld_reg;
    logic [kmep_pkg::BYTE_W-1:0]       rd_reg;
    logic [kmep_pkg::COLOR_W-1:0]      border_out_reg;
    logic                              beeper_out_reg;
    logic [kmep_pkg::PEND_W-1:0]       pend_reg;
    logic                              drop_reg;

    // Port output latches.
    logic [kmep_pkg::COLOR_W-1:0]      border_reg;
    logic [kmep_pkg::COLOR_W-1:0]      border_next;
    logic                              beeper_reg;
    logic                              beeper_next;

    logic                              advance;
    logic                              accept;
    logic                              push;
    logic                              dropped;
    logic [kmep_pkg::BYTE_W-1:0]       rd_next;
    logic [kmep_pkg::KEY_ROWS-1:0]     row_sel;
    logic [kmep_pkg::KEY_COLS-1:0]     row_and;
    logic [kmep_pkg::CNT_W-1:0]        hold_frames;
    logic [kmep_pkg::CNT_W-1:0]        quiet_frames;
    logic                              pop;
    kmep_pkg::key_op_t                 key_op;
    kmep_pkg::queue_stat_t             qstat;
    kmep_pkg::key_matrix_t             matrix;

    // A beat in the input register moves on whenever the output register is
    // free or is being emptied in this cycle.
    assign advance       = in_vld_reg && (!out_vld_reg || results.ready);
    assign items.ready   = !in_vld_reg || advance;
    assign accept        = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (items.ready)
            in_vld_reg <= items.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= items.action;
            ev_reg      <= '{pressed: items.key_pressed, row: items.key_row,
                             col: items.key_col};
            port_reg    <= items.port_address;
            wval_reg    <= items.write_value;
        end
    end

    kmep_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .hold_frames  (hold_frames),
        .quiet_frames (quiet_frames)
    );

    // A key event is queued unless the ring is full, in which case the beat
    // reports the drop.
    assign dropped = (act_reg == kmep_pkg::ACT_ENQUEUE) && qstat.full;
    assign push    = advance && (act_reg == kmep_pkg::ACT_ENQUEUE) && !qstat.full;

    kmep_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (ev_reg),
        .pop       (pop),
        .stat      (qstat)
    );

    // A frame tick runs the release counters and, when the keyboard has been
    // quiet long enough, applies the event at the head of the queue.
    assign key_op.tick    = advance && (act_reg == kmep_pkg::ACT_FRAME_TICK);
    assign key_op.key_set = advance && (act_reg == kmep_pkg::ACT_KEY_SET);
    assign key_op.ev      = ev_reg;

    kmep_keys u_keys
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (key_op),
        .hold_frames  (hold_frames),
        .quiet_frames (quiet_frames),
        .qstat        (qstat),
        .pop          (pop),
        .matrix       (matrix)
    );

    // Port read: each cleared bit of the high address byte selects one
    // half-row, and the selected rows are ANDed. Odd ports read as idle.
    assign row_sel = ~port_reg[kmep_pkg::PORT_W-1 -: kmep_pkg::KEY_ROWS];

    always_comb
    begin
        row_and = kmep_pkg::ROW_ALL_UP;
        for (int r = 0; r < kmep_pkg::KEY_ROWS; r++)
        begin
            if (row_sel[r])
                row_and = row_and & matrix[r];
        end
    end

    always_comb
    begin
        if ((act_reg == kmep_pkg::ACT_PORT_READ) && !port_reg[0])
            rd_next = kmep_pkg::READ_MARK | kmep_pkg::BYTE_W'(row_and);
        else
            rd_next = kmep_pkg::READ_IDLE;
    end

    // Port write at an even address latches border color and beeper.
    always_comb
    begin
        border_next = border_reg;
        beeper_next = beeper_reg;
        if (advance && (act_reg == kmep_pkg::ACT_PORT_WRITE) && !port_reg[0])
        begin
            border_next = wval_reg[kmep_pkg::COLOR_W-1:0];
            beeper_next = wval_reg[kmep_pkg::BEEPER_BIT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg <= kmep_pkg::BORDER_RESET;
            beeper_reg <= 1'b0;
        end
        else
        begin
            border_reg <= border_next;
            beeper_reg <= beeper_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (results.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_reg         <= rd_next;
            border_out_reg <= border_next;
            beeper_out_reg <= beeper_next;
            pend_reg       <= qstat.pending_next;
            drop_reg       <= dropped;
        end
    end

    assign results.valid         = out_vld_reg;
    assign results.read_data     = rd_reg;
    assign results.border_color  = border_out_reg;
    assign results.beeper_level  = beeper_out_reg;
    assign results.queue_pending = pend_reg;
    assign results.event_dropped = drop_reg;

endmodule
